@@ rtl/stable_sorted_priority_queue_core_defines.svh @@
// Assertion macros used by the priority queue datapath (sspq_dp).
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define SSPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sspq assertion failed");
// Checked on every edge, reset included.
`define SSPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("sspq assertion failed");
`else
`define SSPQ_ASSERT(lbl, prop)
`define SSPQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/sspq_pkg.sv @@
// Types and constants of the sorted priority queue.
package sspq_pkg;

    localparam int CAPACITY    = 256;
    localparam int KEY_BITS    = 24;
    localparam int HANDLE_BITS = 10;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OCC_W       = 9;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       compare;
        logic       insert;
        logic       remove;
        logic       emit;
        logic [1:0] code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
    } t_sts;

endpackage

@@ rtl/sspq_ctrl.sv @@
// Request sequencer: accept, compare, update, result handshake.
module sspq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  sspq_pkg::t_sts i_sts,
    output sspq_pkg::t_cmd o_cmd
);
    import sspq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;

    // no request is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || (r_state == S_UPD);

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_accept;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.emit    = (r_state == S_UPD);
        if (i_sts.kind == KIND_INSERT) begin
            o_cmd.insert = (r_state == S_UPD) && !i_sts.full;
            o_cmd.code   = i_sts.full ? ST_FULL : ST_INSERTED;
        end else begin
            o_cmd.remove = (r_state == S_UPD) && !i_sts.empty;
            o_cmd.code   = i_sts.empty ? ST_EMPTY : ST_REMOVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/sspq_dp.sv @@
// Sorted shift store, pair count and result register.
`include "stable_sorted_priority_queue_core_defines.svh"

module sspq_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sspq_pkg::t_cmd                   i_cmd,
    output sspq_pkg::t_sts                   o_sts,
    input  logic                             i_kind,
    input  logic [sspq_pkg::KEY_BITS-1:0]    i_key,
    input  logic [sspq_pkg::HANDLE_BITS-1:0] i_node_handle,
    output logic [sspq_pkg::KEY_BITS-1:0]    o_out_key,
    output logic [sspq_pkg::HANDLE_BITS-1:0] o_out_handle,
    output logic [1:0]                       o_status,
    output logic [sspq_pkg::OCC_W-1:0]       o_occupancy
);
    import sspq_pkg::*;

    logic                   r_kind;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [CAPACITY-1:0]    r_gt;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [KEY_BITS-1:0]    r_keys [CAPACITY];
    logic [HANDLE_BITS-1:0] r_hdls [CAPACITY];
    logic [KEY_BITS-1:0]    r_out_key;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [1:0]             r_status;
    logic [OCC_W-1:0]       r_occupancy;

    assign o_sts.kind  = r_kind;
    assign o_sts.full  = (r_count == CNT_W'(CAPACITY));
    assign o_sts.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) n_count = r_count + CNT_W'(1);
        else if (i_cmd.remove) n_count = r_count - CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_handle <= i_node_handle;
        end
    end

    // Per cell: does the new pair go at or before this slot? Empty slots count as greater.
    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_gt[i] <= (CNT_W'(i) >= r_count) || (r_keys[i] > r_key);
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && r_gt[0]) begin
                    r_keys[0] <= r_key;
                    r_hdls[0] <= r_handle;
                end else if (i_cmd.remove) begin
                    r_keys[0] <= r_keys[1];
                    r_hdls[0] <= r_hdls[1];
                end
            end
        end else if (g == CAPACITY - 1) begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && r_gt[g]) begin
                    r_keys[g] <= r_gt[g-1] ? r_keys[g-1] : r_key;
                    r_hdls[g] <= r_gt[g-1] ? r_hdls[g-1] : r_handle;
                end
            end
        end else begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && r_gt[g]) begin
                    r_keys[g] <= r_gt[g-1] ? r_keys[g-1] : r_key;
                    r_hdls[g] <= r_gt[g-1] ? r_hdls[g-1] : r_handle;
                end else if (i_cmd.remove) begin
                    r_keys[g] <= r_keys[g+1];
                    r_hdls[g] <= r_hdls[g+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_key    <= i_cmd.remove ? r_keys[0] : '0;
            r_out_handle <= i_cmd.remove ? r_hdls[0] : '0;
            r_status     <= i_cmd.code;
            r_occupancy  <= OCC_W'(n_count);
        end
    end

    assign o_out_key    = r_out_key;
    assign o_out_handle = r_out_handle;
    assign o_status     = r_status;
    assign o_occupancy  = r_occupancy;

    `SSPQ_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `SSPQ_ASSERT(a_no_insert_full, i_cmd.insert |-> r_count < CNT_W'(CAPACITY))
    `SSPQ_ASSERT(a_remove_dec, i_cmd.remove |=> r_count == $past(r_count) - CNT_W'(1))
    `SSPQ_ASSERT_ALWAYS(a_one_op, !((i_cmd.insert === 1'b1) && (i_cmd.remove === 1'b1)))

endmodule

@@ rtl/stable_sorted_priority_queue_core.sv @@
// Steps: load on accept, key compare, then the update state registers the result.
// A new request is taken only back in idle, after the compare-then-shift pass over the 256-cell store.
// A waiting result does not block the next request beyond its own handshake.
// Reset (synchronous, active low) empties the queue and clears the handshake state.
// Store contents are undefined after reset; no clearing pass, the pair count guards every read.
module stable_sorted_priority_queue_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [sspq_pkg::KEY_BITS-1:0]    i_key,
    input  logic [sspq_pkg::HANDLE_BITS-1:0] i_node_handle,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sspq_pkg::KEY_BITS-1:0]    o_out_key,
    output logic [sspq_pkg::HANDLE_BITS-1:0] o_out_handle,
    output logic [1:0]                       o_status,
    output logic [sspq_pkg::OCC_W-1:0]       o_occupancy
);
    import sspq_pkg::*;

    // Command and status between sequencer and store.
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: takes a request only when idle and the result slot is free or draining.
    sspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Store: each cell compares its key against the new key in parallel, then shifts
    // right (insert, behind all equal keys) or left (remove from the head).
    sspq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_node_handle (i_node_handle),
        .o_out_key     (o_out_key),
        .o_out_handle  (o_out_handle),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy)
    );

endmodule

@@ test/stable_sorted_priority_queue_core_tb.sv @@
// Testbench for the sorted priority queue: random handshakes, in-bench queue predictor.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_core_tb;
    import sspq_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_WAIT       = 11;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic                   kind;
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
    } t_pq_req;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [HANDLE_BITS-1:0] handle;
        logic [1:0]             status;
        logic [OCC_W-1:0]       occ;
    } t_pq_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   i_kind        = KIND_INSERT;
    logic [KEY_BITS-1:0]    i_key         = '0;
    logic [HANDLE_BITS-1:0] i_node_handle = '0;
    logic                   i_out_ready   = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [KEY_BITS-1:0]    o_out_key;
    logic [HANDLE_BITS-1:0] o_out_handle;
    logic [1:0]             o_status;
    logic [OCC_W-1:0]       o_occupancy;

    stable_sorted_priority_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_node_handle (i_node_handle),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_key     (o_out_key),
        .o_out_handle  (o_out_handle),
        .o_status      (o_status),
        .o_occupancy   (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus waiting to be driven, and results the queue owes us, oldest first.
    t_pq_req    pending_requests[$];
    t_pq_result expected_results[$];
    t_pq_req    cur_req;

    // Shadow copy of the sorted store; only entries below shadow_count are ever read.
    logic [KEY_BITS-1:0]    shadow_keys[CAPACITY];
    logic [HANDLE_BITS-1:0] shadow_handles[CAPACITY];
    int                     shadow_count = 0;

    // Occupancy as the generator sees it, used to steer the stimulus phases.
    int gen_count = 0;

    int n_sent = 0, n_checked = 0, n_mismatch = 0;
    int n_inserts = 0, n_removes = 0, n_refused = 0, n_empty = 0, peak_occ = 0;
    int in_wait = 0, in_quiet = 0, out_wait = 0, out_quiet = 0;
    int idle_cycles = 0;

    // Predict the result of one request and update the shadow store.
    function automatic t_pq_result predict_queue_op(t_pq_req r);
        t_pq_result res;
        int         pos;
        int         i;
        res = '0;
        if (r.kind == KIND_INSERT) begin
            if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
                n_refused++;
            end else begin
                // Stable insert: skip every stored key <= new key.
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] <= r.key) pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_keys[i]    = shadow_keys[i-1];
                    shadow_handles[i] = shadow_handles[i-1];
                end
                shadow_keys[pos]    = r.key;
                shadow_handles[pos] = r.handle;
                shadow_count++;
                res.status = ST_INSERTED;
                n_inserts++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                res.key    = shadow_keys[0];
                res.handle = shadow_handles[0];
                for (i = 0; i < shadow_count - 1; i++) begin
                    shadow_keys[i]    = shadow_keys[i+1];
                    shadow_handles[i] = shadow_handles[i+1];
                end
                shadow_count--;
                res.status = ST_REMOVED;
                n_removes++;
            end
        end
        res.occ = OCC_W'(shadow_count);
        if (shadow_count > peak_occ) peak_occ = shadow_count;
        return res;
    endfunction

    // Wait before the next request/result: drawn from 0 to MAX_WAIT, with occasional zero-wait runs.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(8, 20);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic push_req(logic kind, logic [KEY_BITS-1:0] key,
                            logic [HANDLE_BITS-1:0] handle);
        pending_requests.push_back('{kind: kind, key: key, handle: handle});
        if (kind == KIND_INSERT) begin
            if (gen_count < CAPACITY) gen_count++;
        end else if (gen_count > 0) begin
            gen_count--;
        end
    endtask

    // Mostly tiny keys so ties are common; some extremes and full-range values.
    function automatic logic [KEY_BITS-1:0] rand_key();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) return KEY_BITS'($urandom_range(0, 15));
        if (sel == 10) return '0;
        if (sel == 11) return '1;
        return KEY_BITS'($urandom);
    endfunction

    task automatic random_mix(int count, int insert_pct);
        int  n;
        logic kind;
        for (n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            push_req(kind, rand_key(), HANDLE_BITS'($urandom));
        end
    endtask

    // Request driver: holds a request until accepted, then idles for a drawn wait.
    always @(posedge i_clk) begin
        logic hs;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            hs = i_in_valid && o_in_ready;
            if (hs) begin
                expected_results.push_back(predict_queue_op(cur_req));
                n_sent++;
                in_wait = draw_wait(in_quiet);
            end
            if (i_in_valid && !hs) begin
                // request still waiting for ready: hold everything
            end else if (in_wait > 0 || pending_requests.size() == 0) begin
                if (in_wait > 0) in_wait--;
                i_in_valid    <= 1'b0;
                i_kind        <= 1'($urandom);
                i_key         <= KEY_BITS'($urandom);
                i_node_handle <= HANDLE_BITS'($urandom);
            end else begin
                cur_req = pending_requests.pop_front();
                i_in_valid    <= 1'b1;
                i_kind        <= cur_req.kind;
                i_key         <= cur_req.key;
                i_node_handle <= cur_req.handle;
            end
        end
    end

    // Result monitor: random back-pressure, compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_pq_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (expected_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: unexpected result: key=%h handle=%h st=%0d occ=%0d",
                                 o_out_key, o_out_handle, o_status, o_occupancy);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_key !== want.key || o_out_handle !== want.handle ||
                        o_status !== want.status || o_occupancy !== want.occ) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("ERROR: result %0d: exp key=%h handle=%h st=%0d occ=%0d",
                                     n_checked, want.key, want.handle, want.status,
                                     want.occ);
                            $display("       result %0d: got key=%h handle=%h st=%0d occ=%0d",
                                     n_checked, o_out_key, o_out_handle, o_status,
                                     o_occupancy);
                        end
                    end
                end
                out_wait = draw_wait(out_quiet);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with work outstanding and no handshake on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (pending_requests.size() == 0 && expected_results.size() == 0 && !i_in_valid)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: timeout, %0d results still expected", expected_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int n;

        // Directed: remove on empty, extremes, stable ordering of equal keys.
        push_req(KIND_REMOVE, '1, '1);
        push_req(KIND_INSERT, 24'h000000, 10'h000);
        push_req(KIND_INSERT, 24'hFFFFFF, 10'h3FF);
        push_req(KIND_INSERT, 24'h000005, 10'h001);
        push_req(KIND_INSERT, 24'h000005, 10'h002);
        push_req(KIND_INSERT, 24'h000005, 10'h003);
        push_req(KIND_INSERT, 24'h000000, 10'h155);
        push_req(KIND_INSERT, 24'hAAAAAA, 10'h2AA);
        push_req(KIND_INSERT, 24'h555555, 10'h155);
        push_req(KIND_INSERT, 24'h000004, 10'h007);
        push_req(KIND_INSERT, 24'hFFFFFF, 10'h0AA);
        // drain past empty; key/handle on removes are don't-care garbage
        for (n = 0; n < 11; n++) push_req(KIND_REMOVE, KEY_BITS'($urandom), HANDLE_BITS'($urandom));

        // Random: grow with an insert bias, fill to capacity and push past it,
        // then churn near full with a remove bias.
        random_mix(100, 65);
        while (gen_count < CAPACITY) push_req(KIND_INSERT, rand_key(), HANDLE_BITS'($urandom));
        for (n = 0; n < 3; n++) push_req(KIND_INSERT, rand_key(), HANDLE_BITS'($urandom));
        push_req(KIND_REMOVE, '0, '0);
        push_req(KIND_INSERT, '0, '1);
        push_req(KIND_INSERT, '1, '0);
        random_mix(100, 30);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !i_in_valid);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d requests, %0d results checked, %0d mismatches",
                 n_sent, n_checked, n_mismatch);
        $display("Mix: %0d inserts, %0d removes, %0d refused when full, %0d removes on empty",
                 n_inserts, n_removes, n_refused, n_empty);
        $display("Peak occupancy %0d", peak_occ);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sspq_pkg.sv
rtl/sspq_ctrl.sv
rtl/sspq_dp.sv
rtl/stable_sorted_priority_queue_core.sv
test/stable_sorted_priority_queue_core_tb.sv
